/* sv/lpm_pkg.sv */
package lpm_pkg;

   // Stack geometry.
   localparam int STACK_DEPTH = 1024;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = 11;
   localparam int FREE_RAW_W  = $clog2(STACK_DEPTH + 1);
   localparam int FREE_W      = (FREE_RAW_W > CNT_W) ? FREE_RAW_W : CNT_W;
   localparam int WORD_W      = 64;
   localparam int MODE_W      = 2;

   // Operation codes carried on req_mode.
   localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POP_TO = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

   // Result bookkeeping handed from the controller to the output stage.
   typedef struct packed {
      logic              valid;
      logic              status;
      logic              fwd;
      logic [FREE_W-1:0] free;
   } rsp_ctl_type;

endpackage

/* sv/lifo_stack_with_pop_to_match_top.sv */
// Channel   Handshake            Ports
// request   start && !busy       req_mode, req_value
// response  rsp_valid (1 cycle)  rsp_status, rsp_top_valid, rsp_top_value,
//                                rsp_next_valid, rsp_next_value,
//                                rsp_used_count, rsp_free_count
//
// Push, pop, clear and pop-to on an empty stack: the result appears in the
// cycle after the accepting edge, and busy stays low (one per cycle). Pop-to
// on a stored stack: busy is high while the walk discards entries until a
// match is left on top, or until the stack is empty when no entry matches.
// The walk compares one stored word per cycle on memory read port A. The
// result is on the ports in the first cycle with busy low again.
// Reset empties the stack; the word memory is not cleared. The receiver
// cannot stall the response.
module lifo_stack_with_pop_to_match_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [lpm_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [lpm_pkg::WORD_W-1:0] req_value,
   output logic                              rsp_valid,
   output logic                              rsp_status,
   output logic                              rsp_top_valid,
   output logic signed [lpm_pkg::WORD_W-1:0] rsp_top_value,
   output logic                              rsp_next_valid,
   output logic signed [lpm_pkg::WORD_W-1:0] rsp_next_value,
   output logic [lpm_pkg::CNT_W-1:0]         rsp_used_count,
   output logic [lpm_pkg::CNT_W-1:0]         rsp_free_count
);

   import lpm_pkg::*;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [WORD_W-1:0] rd_data_a;
   logic [WORD_W-1:0] rd_data_b;
   logic [WORD_W-1:0] hold_value;
   rsp_ctl_type       rsp_ctl;
   logic [FREE_W-1:0] used;
   logic [WORD_W-1:0] top_word;

   lpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_mode   (req_mode),
      .req_value  (req_value),
      .rd_data_a  (rd_data_a),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .hold_value (hold_value),
      .rsp_ctl    (rsp_ctl)
   );

   lpm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH),
      .AW    (ADDR_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_value),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // A push writes the top entry in the same cycle it is read, so the
   // pushed word is forwarded in place of the stale read data.
   assign top_word = rsp_ctl.fwd ? hold_value : rd_data_a;

   // Result formatting.
   assign used           = FREE_W'(STACK_DEPTH) - rsp_ctl.free;
   assign rsp_valid      = rsp_ctl.valid;
   assign rsp_status     = rsp_ctl.status;
   assign rsp_top_valid  = (rsp_ctl.free != FREE_W'(STACK_DEPTH));
   assign rsp_next_valid = (rsp_ctl.free < FREE_W'(STACK_DEPTH - 1));
   assign rsp_top_value  = rsp_top_valid ? top_word : '0;
   assign rsp_next_value = rsp_next_valid ? rd_data_b : '0;
   assign rsp_used_count = used[CNT_W-1:0];
   assign rsp_free_count = rsp_ctl.free[CNT_W-1:0];

endmodule

/* sv/lpm_ram.sv */
module lpm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   // One write port, two registered read ports; a read of the entry being
   // written returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

/* sv/lpm_ctrl.sv */
module lpm_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [lpm_pkg::MODE_W-1:0]            req_mode,
   input  logic signed [lpm_pkg::WORD_W-1:0]     req_value,
   input  logic [lpm_pkg::WORD_W-1:0]            rd_data_a,
   output logic                                  wr_en,
   output logic [lpm_pkg::ADDR_W-1:0]            wr_addr,
   output logic [lpm_pkg::ADDR_W-1:0]            rd_addr_a,
   output logic [lpm_pkg::ADDR_W-1:0]            rd_addr_b,
   output logic [lpm_pkg::WORD_W-1:0]            hold_value,
   output lpm_pkg::rsp_ctl_type                  rsp_ctl
);

   import lpm_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   localparam logic [FREE_W-1:0] FREE_FULL = FREE_W'(STACK_DEPTH);

   logic              state_ff, state_in;
   logic [FREE_W-1:0] free_ff, free_in;
   logic [WORD_W-1:0] value_ff, value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              status_ff, status_in;
   logic              fwd_ff, fwd_in;
   logic              accept;
   logic [FREE_W-1:0] free_inc;
   logic [FREE_W-1:0] free_dec;
   logic [FREE_W-1:0] next_idx;

   assign busy     = (state_ff == ST_WALK);
   assign accept   = start && !busy;
   assign free_inc = free_ff + 1'b1;
   assign free_dec = free_ff - 1'b1;

   // Next-state logic: one transaction per accept, or one entry per cycle
   // while walking down the stack for a pop-to.
   always_comb begin
      state_in     = state_ff;
      free_in      = free_ff;
      value_in     = value_ff;
      rsp_valid_in = 1'b0;
      status_in    = 1'b0;
      fwd_in       = 1'b0;
      wr_en        = 1'b0;
      if (state_ff == ST_WALK) begin
         if (rd_data_a == value_ff) begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            free_in = free_inc;
            if (free_inc == FREE_FULL) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      end else if (accept) begin
         value_in = req_value;
         case (req_mode)
            MODE_PUSH: begin
               rsp_valid_in = 1'b1;
               if (free_ff == '0) begin
                  status_in = 1'b1;
               end else begin
                  free_in = free_dec;
                  wr_en   = 1'b1;
                  fwd_in  = 1'b1;
               end
            end
            MODE_POP: begin
               rsp_valid_in = 1'b1;
               if (free_ff == FREE_FULL) begin
                  status_in = 1'b1;
               end else begin
                  free_in = free_inc;
               end
            end
            MODE_POP_TO: begin
               if (free_ff == FREE_FULL) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_WALK;
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
               free_in      = FREE_FULL;
            end
         endcase
      end
   end

   // The memory is always read at the new top and the entry below it.
   assign next_idx  = free_in + 1'b1;
   assign rd_addr_a = free_in[ADDR_W-1:0];
   assign rd_addr_b = next_idx[ADDR_W-1:0];
   assign wr_addr   = free_in[ADDR_W-1:0];

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_ff      <= FREE_FULL;
         rsp_valid_ff <= 1'b0;
         status_ff    <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         fwd_ff       <= fwd_in;
      end
   end

   // Pushed or searched word; no reset needed.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign hold_value     = value_ff;
   assign rsp_ctl.valid  = rsp_valid_ff;
   assign rsp_ctl.status = status_ff;
   assign rsp_ctl.fwd    = fwd_ff;
   assign rsp_ctl.free   = free_ff;

`ifndef SYNTHESIS
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FREE_FULL)
      else $error("free slot count exceeds stack depth");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> free_ff < FREE_FULL)
      else $error("pop-to walk on an empty stack");

   a_walk_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> !rsp_valid_ff)
      else $error("result strobe during pop-to walk");

   a_push_dec: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == MODE_PUSH && free_ff != '0
      |=> free_ff == $past(free_dec) && fwd_ff)
      else $error("push did not take a slot");

   a_simple_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode != MODE_POP_TO |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("missing result after a single-cycle transaction");
`endif

endmodule
